/* design/zero_run_length_decoder_top_defines.svh */
// Assertion macros shared by the zero run-length decoder RTL.
// No dependencies; each asserting module includes this file in its body.
`ifndef ZERO_RUN_LENGTH_DECODER_TOP_DEFINES_SVH
`define ZERO_RUN_LENGTH_DECODER_TOP_DEFINES_SVH
`ifndef SYNTH
`define ZRLD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ZRLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ZRLD_ASSERT_IMP(label, ante, cons, msg)
`define ZRLD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/zrld_pkg.sv */
// Shared types and constants for the zero run-length decoder.
// No dependencies; used by the interfaces and every module.
package zrld_pkg;

    localparam int POS_W         = 48;
    localparam int LEN_W         = 32;
    localparam int BYTE_W        = 8;
    localparam int LEN_BYTES     = 4;
    localparam int LEN_CNT_W     = $clog2(LEN_BYTES);
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [BYTE_W-1:0] TAG_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] TAG_LIT  = 8'h01;

    localparam logic [CFG_INDEX_W-1:0] CFG_DECODED_TOTAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENCODED_TOTAL = 2'd1;

    typedef enum logic [1:0] {
        KIND_LITERAL,
        KIND_ZERO_RUN,
        KIND_FINISHED,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_OFFSET,
        ERR_WIRE_OVERRUN,
        ERR_TAG,
        ERR_ZERO_LEN,
        ERR_LOGICAL_OVERRUN,
        ERR_TRUNCATED,
        ERR_TRAILING
    } err_code_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR,
        OP_FIN,
        OP_LEN,
        OP_LIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        err_code_t         code;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              zero_run;
    } cmd_t;

endpackage

/* design/zrld_intf.sv */
// Channel interfaces of the zero run-length decoder: stream, result, cfg.
// Depends on zrld_pkg.
interface zrld_stream_if;
    import zrld_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] wire_byte;
    logic [POS_W-1:0]  byte_position;
    modport source (output valid, func, wire_byte, byte_position, input ready);
    modport sink (input valid, func, wire_byte, byte_position, output ready);
endinterface

interface zrld_result_if;
    import zrld_pkg::*;
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  run_length;
    logic [POS_W-1:0]  logical_offset;
    err_code_t         error_code;
    modport source (output valid, kind, data_byte, run_length, logical_offset, error_code,
                    input ready);
    modport sink (input valid, kind, data_byte, run_length, logical_offset, error_code,
                  output ready);
endinterface

interface zrld_cfg_if;
    import zrld_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [POS_W-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/zrld_front.sv */
// Front end: accepts stream beats, parses records, checks wire offsets and size.
// Depends on zrld_pkg and zrld_stream_if; pushes one command per beat into the queue.
module zrld_front (
    input  logic                       clk,
    input  logic                       rst_n,
    zrld_stream_if.sink                stream,
    input  logic [zrld_pkg::POS_W-1:0] encoded_total,
    input  logic                       q_full,
    output logic                       push,
    output zrld_pkg::cmd_t             cmd
);
    import zrld_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_LIT
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  zero_run_reg, zero_run_next;
    logic [LEN_W-1:0]      len_acc_reg, len_acc_next;
    logic [LEN_CNT_W-1:0]  len_cnt_reg, len_cnt_next;
    logic [LEN_W-1:0]      remaining_reg, remaining_next;
    logic [POS_W-1:0]      consumed_reg, consumed_next;
    logic [LEN_W-1:0]      acc_new;

    assign stream.ready = !q_full;
    assign push         = stream.valid && !q_full;
    assign acc_new      = len_acc_reg | (LEN_W'(stream.wire_byte) << {len_cnt_reg, 3'b000});

    always_comb
    begin
        phase_next     = phase_reg;
        zero_run_next  = zero_run_reg;
        len_acc_next   = len_acc_reg;
        len_cnt_next   = len_cnt_reg;
        remaining_next = remaining_reg;
        consumed_next  = consumed_reg;
        cmd.op         = OP_NONE;
        cmd.code       = ERR_NONE;
        cmd.data       = stream.wire_byte;
        cmd.len        = acc_new;
        cmd.zero_run   = zero_run_reg;
        if (push)
        begin
            if (stream.func)
            begin
                cmd.op = OP_FIN;
                if (consumed_reg != encoded_total || phase_reg != PH_TAG)
                begin
                    cmd.code = ERR_TRUNCATED;
                end
            end
            else if (stream.byte_position != consumed_reg)
            begin
                cmd.op   = OP_ERR;
                cmd.code = ERR_OFFSET;
            end
            else if (consumed_reg >= encoded_total)
            begin
                cmd.op   = OP_ERR;
                cmd.code = ERR_WIRE_OVERRUN;
            end
            else
            begin
                consumed_next = consumed_reg + POS_W'(1);
                case (phase_reg)
                    PH_LEN:
                    begin
                        len_acc_next = acc_new;
                        len_cnt_next = len_cnt_reg + LEN_CNT_W'(1);
                        if (len_cnt_reg == LEN_CNT_W'(LEN_BYTES - 1))
                        begin
                            if (acc_new == '0)
                            begin
                                cmd.op   = OP_ERR;
                                cmd.code = ERR_ZERO_LEN;
                            end
                            else
                            begin
                                cmd.op         = OP_LEN;
                                remaining_next = acc_new;
                                phase_next     = zero_run_reg ? PH_TAG : PH_LIT;
                            end
                        end
                    end
                    PH_LIT:
                    begin
                        cmd.op         = OP_LIT;
                        remaining_next = remaining_reg - LEN_W'(1);
                        if (remaining_reg == LEN_W'(1))
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    default:
                    begin
                        if (!(stream.wire_byte inside {TAG_ZERO, TAG_LIT}))
                        begin
                            cmd.op   = OP_ERR;
                            cmd.code = ERR_TAG;
                        end
                        else
                        begin
                            zero_run_next = (stream.wire_byte == TAG_ZERO);
                            len_acc_next  = '0;
                            len_cnt_next  = '0;
                            phase_next    = PH_LEN;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            zero_run_reg  <= 1'b0;
            len_acc_reg   <= '0;
            len_cnt_reg   <= '0;
            remaining_reg <= '0;
            consumed_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            zero_run_reg  <= zero_run_next;
            len_acc_reg   <= len_acc_next;
            len_cnt_reg   <= len_cnt_next;
            remaining_reg <= remaining_next;
            consumed_reg  <= consumed_next;
        end
    end

endmodule

/* design/zrld_fifo.sv */
// Command queue between front and back end.
// Depends on zrld_pkg for the command type and depth; uses the assertion macros.
module zrld_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  zrld_pkg::cmd_t push_data,
    input  logic           pop,
    output zrld_pkg::cmd_t pop_data,
    output logic           full,
    output logic           not_empty
);
    import zrld_pkg::*;
    `include "zero_run_length_decoder_top_defines.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `ZRLD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
    `ZRLD_ASSERT_NEXT(a_push_grows, push && !do_pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "push lost")

endmodule

/* design/zrld_back.sv */
// Back end: tracks decoded bytes, checks logical room, holds the sticky error.
// Depends on zrld_pkg and zrld_result_if; drives the registered result channel.
module zrld_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  zrld_pkg::cmd_t             entry,
    output logic                       pop,
    input  logic [zrld_pkg::POS_W-1:0] decoded_total,
    zrld_result_if.source              result
);
    import zrld_pkg::*;
    `include "zero_run_length_decoder_top_defines.svh"

    err_code_t          sticky_reg, sticky_next;
    logic [POS_W-1:0]   produced_reg, produced_next;
    logic               out_valid_reg;
    kind_t              out_kind_reg, kind_next;
    logic [BYTE_W-1:0]  out_data_reg, data_next;
    logic [LEN_W-1:0]   out_run_reg, run_next;
    logic [POS_W-1:0]   out_offset_reg;
    err_code_t          out_code_reg, code_next;
    logic               has_result;
    logic [POS_W-1:0]   room;
    logic               room_len;
    logic               room_one;

    assign pop      = q_valid && (!out_valid_reg || result.ready);
    assign room     = decoded_total - produced_reg;
    assign room_len = (produced_reg <= decoded_total) && (POS_W'(entry.len) <= room);
    assign room_one = produced_reg < decoded_total;

    always_comb
    begin
        has_result    = 1'b0;
        kind_next     = KIND_ERROR;
        data_next     = '0;
        run_next      = '0;
        code_next     = ERR_NONE;
        sticky_next   = sticky_reg;
        produced_next = produced_reg;
        if (sticky_reg != ERR_NONE)
        begin
            has_result = 1'b1;
            code_next  = sticky_reg;
        end
        else
        begin
            case (entry.op)
                OP_ERR:
                begin
                    has_result = 1'b1;
                    code_next  = entry.code;
                end
                OP_FIN:
                begin
                    has_result = 1'b1;
                    if (entry.code != ERR_NONE)
                    begin
                        code_next = entry.code;
                    end
                    else if (produced_reg != decoded_total)
                    begin
                        code_next = ERR_TRAILING;
                    end
                    else
                    begin
                        kind_next = KIND_FINISHED;
                    end
                end
                OP_LEN:
                begin
                    if (!room_len)
                    begin
                        has_result = 1'b1;
                        code_next  = ERR_LOGICAL_OVERRUN;
                    end
                    else if (entry.zero_run)
                    begin
                        has_result    = 1'b1;
                        kind_next     = KIND_ZERO_RUN;
                        run_next      = entry.len;
                        produced_next = produced_reg + POS_W'(entry.len);
                    end
                end
                OP_LIT:
                begin
                    has_result = 1'b1;
                    if (!room_one)
                    begin
                        code_next = ERR_LOGICAL_OVERRUN;
                    end
                    else
                    begin
                        kind_next     = KIND_LITERAL;
                        data_next     = entry.data;
                        run_next      = LEN_W'(1);
                        produced_next = produced_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
            sticky_next = code_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg    <= ERR_NONE;
            produced_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            sticky_reg    <= sticky_next;
            produced_reg  <= produced_next;
            out_valid_reg <= has_result;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && has_result)
        begin
            out_kind_reg   <= kind_next;
            out_data_reg   <= data_next;
            out_run_reg    <= run_next;
            out_offset_reg <= produced_reg;
            out_code_reg   <= code_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_kind_reg;
    assign result.data_byte      = out_data_reg;
    assign result.run_length     = out_run_reg;
    assign result.logical_offset = out_offset_reg;
    assign result.error_code     = out_code_reg;

    `ZRLD_ASSERT_NEXT(a_sticky_holds, sticky_reg != ERR_NONE, sticky_reg == $past(sticky_reg), "sticky error changed")
    `ZRLD_ASSERT_NEXT(a_frozen_on_error, sticky_reg != ERR_NONE, produced_reg == $past(produced_reg), "count moved after error")
    `ZRLD_ASSERT_IMP(a_error_kind, out_valid_reg, (out_kind_reg == KIND_ERROR) == (out_code_reg != ERR_NONE), "error code and kind disagree")

endmodule

/* design/zero_run_length_decoder_top.sv */
// Zero run-length decoder top level: config registers, front end, queue, back end.
// Depends on zrld_pkg, zrld_intf, zrld_front, zrld_fifo and zrld_back.
//
// Channel  Direction  Handshake    Payload
// stream   in         valid/ready  func, wire_byte, byte_position
// result   out        valid/ready  kind, data_byte, run_length, logical_offset, error_code
// cfg      in         valid/ready  index, data (ready always high)
//
// Sustains one beat per cycle unless the queue is full; the front end parses a byte in
// the cycle it is accepted. Its result passes through the queue, then the result register.
// The four-entry queue lets stream keep flowing for four beats while result is stalled.
// Reset clears parse state, counters, sticky error and both size registers; no clearing pass.
module zero_run_length_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    zrld_stream_if.sink   stream,
    zrld_result_if.source result,
    zrld_cfg_if.sink      cfg
);
    import zrld_pkg::*;

    logic [POS_W-1:0] decoded_total_reg;
    logic [POS_W-1:0] encoded_total_reg;
    logic             q_full;
    logic             q_not_empty;
    logic             push;
    logic             pop;
    cmd_t             push_cmd;
    cmd_t             head_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_total_reg <= '0;
            encoded_total_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DECODED_TOTAL: decoded_total_reg <= cfg.data;
                CFG_ENCODED_TOTAL: encoded_total_reg <= cfg.data;
                default:           decoded_total_reg <= decoded_total_reg;
            endcase
        end
    end

    zrld_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream        (stream),
        .encoded_total (encoded_total_reg),
        .q_full        (q_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    zrld_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (head_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    zrld_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .entry         (head_cmd),
        .pop           (pop),
        .decoded_total (decoded_total_reg),
        .result        (result)
    );

endmodule

/* bench/zero_run_length_decoder_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the zero run-length decoder: directed table, random records, then a stream fault.
// Depends on zrld_pkg, the zrld channel interfaces and zero_run_length_decoder_top.
module zero_run_length_decoder_top_tb;
    import zrld_pkg::*;

    localparam logic [POS_W-1:0] MAX48 = '1;
    localparam int SETTLE_CYCLES = 6;
    localparam int TARGET_BEATS = 900;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  run_length;
        logic [POS_W-1:0]  logical_offset;
        err_code_t         error_code;
    } decoded_t;

    localparam decoded_t NO_RESULT = '0;

    typedef enum logic [1:0] {PARSE_TAG, PARSE_LEN, PARSE_LIT} parse_phase_t;
    typedef enum logic [1:0] {ROW_BYTE, ROW_FINISH, ROW_SET_LOGICAL, ROW_SET_WIRE} row_op_t;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_GIVEN} exp_mode_t;
    typedef enum logic [3:0] {
        PLAN_OFFSET,
        PLAN_WIRE_OVERRUN,
        PLAN_BAD_TAG,
        PLAN_ZERO_LEN,
        PLAN_LEN_OVERRUN,
        PLAN_LIT_OVERRUN,
        PLAN_OPEN_RECORD,
        PLAN_WIRE_SHORT,
        PLAN_TRAILING
    } fault_plan_t;

    typedef struct packed {
        row_op_t           what;
        logic [BYTE_W-1:0] data_in;
        logic [POS_W-1:0]  value;
        exp_mode_t         mode;
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  run_length;
        logic [POS_W-1:0]  logical_offset;
        err_code_t         error_code;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [23] = '{
        '{ROW_FINISH, 8'hFF, MAX48, EXP_GIVEN, KIND_FINISHED, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_SET_LOGICAL, 8'h00, MAX48, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_SET_WIRE, 8'h00, MAX48, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h01, 48'd0, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h02, 48'd1, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd2, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd3, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd4, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd5, EXP_GIVEN, KIND_LITERAL, 8'h00, 32'h1, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'hFF, 48'd6, EXP_GIVEN, KIND_LITERAL, 8'hFF, 32'h1, 48'h1, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd7, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'hFF, 48'd8, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'hFF, 48'd9, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'hFF, 48'd10, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'hFF, 48'd11, EXP_GIVEN, KIND_ZERO_RUN, 8'h00, 32'hFFFF_FFFF, 48'h2,
          ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd12, EXP_PREDICT, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h01, 48'd13, EXP_PREDICT, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd14, EXP_PREDICT, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd15, EXP_PREDICT, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_BYTE, 8'h00, 48'd16, EXP_PREDICT, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_SET_WIRE, 8'h00, 48'd17, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0, 48'h0, ERR_NONE},
        '{ROW_SET_LOGICAL, 8'h00, 48'h1_0000_0002, EXP_NONE, KIND_LITERAL, 8'h00, 32'h0,
          48'h0, ERR_NONE},
        '{ROW_FINISH, 8'h00, 48'd0, EXP_GIVEN, KIND_FINISHED, 8'h00, 32'h0, 48'h1_0000_0002,
          ERR_NONE}
    };

    logic clk = 1'b0;
    logic rst_n;

    zrld_stream_if stream_ch ();
    zrld_result_if result_ch ();
    zrld_cfg_if    cfg_ch ();

    zero_run_length_decoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [POS_W-1:0]     decoded_total_q;
    logic [POS_W-1:0]     encoded_total_q;
    parse_phase_t         parse_q;
    logic                 is_zero_run_q;
    logic [LEN_W-1:0]     length_q;
    logic [2:0]           len_count_q;
    logic [LEN_W-1:0]     remaining_q;
    logic [POS_W-1:0]     wire_consumed_q;
    logic [POS_W-1:0]     logical_produced_q;
    err_code_t            failed_code;

    decoded_t decoded_due [$];
    decoded_t seen_res;
    decoded_t want_res;
    int       mismatches;
    int       beats_sent;
    bit       source_gaps;
    bit       sink_stalls;
    int       stall_left;

    function automatic logic [POS_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[POS_W-1:0];
    endfunction

    function automatic bit room_for(input logic [POS_W-1:0] n);
        if (logical_produced_q > decoded_total_q)
        begin
            return 1'b0;
        end
        return n <= decoded_total_q - logical_produced_q;
    endfunction

    function automatic bit raise_fault(input err_code_t code, output decoded_t r);
        failed_code = code;
        r = '{KIND_ERROR, 8'h00, 32'h0, logical_produced_q, code};
        return 1'b1;
    endfunction

    function automatic bit decode_beat(input logic fin, input logic [BYTE_W-1:0] b,
                                       input logic [POS_W-1:0] pos, output decoded_t r);
        logic [POS_W-1:0] start;
        start = logical_produced_q;
        r = NO_RESULT;
        if (failed_code != ERR_NONE)
        begin
            r = '{KIND_ERROR, 8'h00, 32'h0, logical_produced_q, failed_code};
            return 1'b1;
        end
        if (fin)
        begin
            if (wire_consumed_q != encoded_total_q || parse_q != PARSE_TAG)
            begin
                return raise_fault(ERR_TRUNCATED, r);
            end
            if (logical_produced_q != decoded_total_q)
            begin
                return raise_fault(ERR_TRAILING, r);
            end
            r = '{KIND_FINISHED, 8'h00, 32'h0, logical_produced_q, ERR_NONE};
            return 1'b1;
        end
        if (pos != wire_consumed_q)
        begin
            return raise_fault(ERR_OFFSET, r);
        end
        if (wire_consumed_q >= encoded_total_q)
        begin
            return raise_fault(ERR_WIRE_OVERRUN, r);
        end
        wire_consumed_q = wire_consumed_q + 48'd1;
        case (parse_q)
            PARSE_LEN:
            begin
                length_q[8*len_count_q[1:0] +: 8] = b;
                len_count_q = len_count_q + 3'd1;
                if (len_count_q < 3'(LEN_BYTES))
                begin
                    return 1'b0;
                end
                if (length_q == '0)
                begin
                    return raise_fault(ERR_ZERO_LEN, r);
                end
                if (!room_for({16'h0, length_q}))
                begin
                    return raise_fault(ERR_LOGICAL_OVERRUN, r);
                end
                if (is_zero_run_q)
                begin
                    logical_produced_q = logical_produced_q + {16'h0, length_q};
                    remaining_q = '0;
                    parse_q = PARSE_TAG;
                    r = '{KIND_ZERO_RUN, 8'h00, length_q, start, ERR_NONE};
                    return 1'b1;
                end
                remaining_q = length_q;
                parse_q = PARSE_LIT;
                return 1'b0;
            end
            PARSE_LIT:
            begin
                if (!room_for(48'd1))
                begin
                    return raise_fault(ERR_LOGICAL_OVERRUN, r);
                end
                logical_produced_q = logical_produced_q + 48'd1;
                remaining_q = remaining_q - 32'd1;
                if (remaining_q == '0)
                begin
                    parse_q = PARSE_TAG;
                end
                r = '{KIND_LITERAL, b, 32'h1, start, ERR_NONE};
                return 1'b1;
            end
            default:
            begin
                if (b != TAG_ZERO && b != TAG_LIT)
                begin
                    return raise_fault(ERR_TAG, r);
                end
                is_zero_run_q = (b == TAG_ZERO);
                length_q = '0;
                len_count_q = '0;
                parse_q = PARSE_LEN;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_beat(input logic fin, input logic [BYTE_W-1:0] b,
                             input logic [POS_W-1:0] pos, input exp_mode_t mode,
                             input decoded_t given);
        int       gap;
        int       pick;
        bit       produces;
        decoded_t outcome;
        gap = 0;
        if (source_gaps)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 98)
                gap = $urandom_range(20, 60);
            else if (pick >= 90)
                gap = $urandom_range(4, 10);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid         <= 1'b1;
        stream_ch.func          <= fin;
        stream_ch.wire_byte     <= b;
        stream_ch.byte_position <= pos;
        do @(posedge clk); while (!stream_ch.ready);
        produces = decode_beat(fin, b, pos, outcome);
        case (mode)
            EXP_PREDICT:
            begin
                if (produces)
                    decoded_due.push_back(outcome);
            end
            EXP_GIVEN: decoded_due.push_back(given);
            default: ;
        endcase
        beats_sent++;
    endtask

    task automatic send_record(input bit is_zero, input logic [LEN_W-1:0] len, input int cut);
        int                total;
        logic [BYTE_W-1:0] b;
        total = is_zero ? 5 : 5 + int'(len);
        for (int i = 0; i < total && i < cut; i++)
        begin
            if (i == 0)
                b = is_zero ? TAG_ZERO : TAG_LIT;
            else if (i < 5)
                b = len[8*(i-1) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            send_beat(1'b0, b, wire_consumed_q, EXP_PREDICT, NO_RESULT);
        end
    endtask

    task automatic drain_results();
        stream_ch.valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_INDEX_W-1:0] idx, input logic [POS_W-1:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == CFG_DECODED_TOTAL)
            decoded_total_q = value;
        else
            encoded_total_q = value;
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!sink_stalls)
        begin
            result_ch.ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin result_ch.ready <= 1'b0; stall_left = $urandom_range(0, 3); end
                4: begin result_ch.ready <= 1'b0; stall_left = $urandom_range(10, 40); end
                default: result_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen_res = '{result_ch.kind, result_ch.data_byte, result_ch.run_length,
                         result_ch.logical_offset, result_ch.error_code};
            if (decoded_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: kind=%0d data=%h run=%h off=%h err=%0d",
                             seen_res.kind, seen_res.data_byte, seen_res.run_length,
                             seen_res.logical_offset, seen_res.error_code);
            end
            else
            begin
                want_res = decoded_due.pop_front();
                if (seen_res !== want_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: want kind=%0d data=%h run=%h off=%h err=%0d, %s",
                                 want_res.kind, want_res.data_byte, want_res.run_length,
                                 want_res.logical_offset, want_res.error_code,
                                 $sformatf("got kind=%0d data=%h run=%h off=%h err=%0d",
                                           seen_res.kind, seen_res.data_byte,
                                           seen_res.run_length, seen_res.logical_offset,
                                           seen_res.error_code));
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        stim_row_t        row;
        decoded_t         given;
        int               nrec;
        int               pick;
        int               k;
        bit               rec_zero [6];
        logic [LEN_W-1:0] rec_len [6];
        logic [POS_W-1:0] plan_wire;
        logic [POS_W-1:0] plan_log;
        logic [POS_W-1:0] pos;
        bit               exact_first;
        fault_plan_t      plan;

        rst_n                   = 1'b0;
        stream_ch.valid         = 1'b0;
        stream_ch.func          = 1'b0;
        stream_ch.wire_byte     = '0;
        stream_ch.byte_position = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        result_ch.ready         = 1'b0;
        source_gaps             = 1'b0;
        sink_stalls             = 1'b0;
        stall_left              = 0;
        mismatches              = 0;
        beats_sent              = 0;
        decoded_total_q         = '0;
        encoded_total_q         = '0;
        parse_q                 = PARSE_TAG;
        is_zero_run_q           = 1'b0;
        length_q                = '0;
        len_count_q             = '0;
        remaining_q             = '0;
        wire_consumed_q         = '0;
        logical_produced_q      = '0;
        failed_code             = ERR_NONE;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            row = DIRECTED_ROWS[i];
            given = '{row.kind, row.data_byte, row.run_length, row.logical_offset,
                      row.error_code};
            case (row.what)
                ROW_SET_LOGICAL: write_size(CFG_DECODED_TOTAL, row.value);
                ROW_SET_WIRE: write_size(CFG_ENCODED_TOTAL, row.value);
                default: send_beat(row.what == ROW_FINISH, row.data_in, row.value,
                                   row.mode, given);
            endcase
        end

        while (beats_sent < TARGET_BEATS)
        begin
            source_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            nrec = $urandom_range(1, 6);
            plan_wire = '0;
            plan_log = '0;
            for (int r = 0; r < nrec; r++)
            begin
                rec_zero[r] = ($urandom_range(0, 2) == 0);
                pick = $urandom_range(0, 9);
                if (rec_zero[r])
                begin
                    if (pick < 6)
                        rec_len[r] = 32'($urandom_range(1, 16));
                    else if (pick < 9)
                        rec_len[r] = ($urandom == 0) ? 32'd1 : 32'($urandom);
                    else
                        rec_len[r] = 32'hFFFF_FFFF;
                end
                else
                begin
                    rec_len[r] = (pick < 8) ? 32'($urandom_range(1, 6))
                                            : 32'($urandom_range(7, 40));
                end
                plan_wire = plan_wire + (rec_zero[r] ? 48'd5 : 48'd5 + {16'h0, rec_len[r]});
                plan_log = plan_log + {16'h0, rec_len[r]};
            end
            exact_first = ($urandom_range(0, 1) != 0);
            if (exact_first)
            begin
                write_size(CFG_DECODED_TOTAL, logical_produced_q + plan_log);
                write_size(CFG_ENCODED_TOTAL, wire_consumed_q + plan_wire);
            end
            else if ($urandom_range(0, 1) != 0)
            begin
                write_size(CFG_DECODED_TOTAL, MAX48);
                write_size(CFG_ENCODED_TOTAL, MAX48);
            end
            else
            begin
                write_size(CFG_DECODED_TOTAL,
                           logical_produced_q + plan_log + 48'($urandom_range(1, 1000)));
                write_size(CFG_ENCODED_TOTAL,
                           wire_consumed_q + plan_wire + 48'($urandom_range(1, 1000)));
            end
            for (int r = 0; r < nrec; r++)
            begin
                send_record(rec_zero[r], rec_len[r], 64);
                if ($urandom_range(0, 7) == 0)
                    drain_results();
            end
            if (!exact_first)
            begin
                write_size(CFG_ENCODED_TOTAL, wire_consumed_q);
                write_size(CFG_DECODED_TOTAL, logical_produced_q);
            end
            send_beat(1'b1, 8'($urandom_range(0, 255)), rand48(), EXP_PREDICT, NO_RESULT);
        end

        // the first error is sticky and reset comes only once, so fault the stream last
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        write_size(CFG_DECODED_TOTAL, MAX48);
        write_size(CFG_ENCODED_TOTAL, MAX48);
        plan = fault_plan_t'($urandom_range(0, 8));
        case (plan)
            PLAN_OFFSET:
            begin
                pos = rand48();
                if (pos == wire_consumed_q)
                    pos = ~pos;
                send_beat(1'b0, 8'($urandom_range(0, 255)), pos, EXP_PREDICT, NO_RESULT);
            end
            PLAN_WIRE_OVERRUN:
            begin
                write_size(CFG_ENCODED_TOTAL, wire_consumed_q);
                send_beat(1'b0, TAG_LIT, wire_consumed_q, EXP_PREDICT, NO_RESULT);
            end
            PLAN_BAD_TAG:
                send_beat(1'b0, 8'($urandom_range(2, 255)), wire_consumed_q, EXP_PREDICT,
                          NO_RESULT);
            PLAN_ZERO_LEN:
                send_record(bit'($urandom_range(0, 1)), 32'd0, 64);
            PLAN_LEN_OVERRUN:
            begin
                k = $urandom_range(0, 5);
                write_size(CFG_DECODED_TOTAL, logical_produced_q + 48'(k));
                send_record(bit'($urandom_range(0, 1)), 32'(k + 1 + $urandom_range(0, 3)), 64);
            end
            PLAN_LIT_OVERRUN:
            begin
                send_record(1'b0, 32'd6, 7);
                write_size(CFG_DECODED_TOTAL,
                           logical_produced_q - 48'($urandom_range(0, 1)));
                send_beat(1'b0, 8'($urandom_range(0, 255)), wire_consumed_q, EXP_PREDICT,
                          NO_RESULT);
            end
            PLAN_OPEN_RECORD:
            begin
                send_record(1'b0, 32'd8, $urandom_range(1, 7));
                write_size(CFG_ENCODED_TOTAL, wire_consumed_q);
                send_beat(1'b1, 8'($urandom_range(0, 255)), rand48(), EXP_PREDICT, NO_RESULT);
            end
            PLAN_WIRE_SHORT:
            begin
                write_size(CFG_ENCODED_TOTAL, wire_consumed_q + 48'($urandom_range(1, 100)));
                write_size(CFG_DECODED_TOTAL, logical_produced_q);
                send_beat(1'b1, 8'($urandom_range(0, 255)), rand48(), EXP_PREDICT, NO_RESULT);
            end
            default:
            begin
                write_size(CFG_ENCODED_TOTAL, wire_consumed_q);
                write_size(CFG_DECODED_TOTAL, logical_produced_q + 48'($urandom_range(1, 100)));
                send_beat(1'b1, 8'($urandom_range(0, 255)), rand48(), EXP_PREDICT, NO_RESULT);
            end
        endcase
        repeat (6)
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), rand48(),
                      EXP_PREDICT, NO_RESULT);

        drain_results();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* zero_run_length_decoder_top.f */
+incdir+design
design/zrld_pkg.sv
design/zrld_intf.sv
design/zrld_front.sv
design/zrld_fifo.sv
design/zrld_back.sv
design/zero_run_length_decoder_top.sv
bench/zero_run_length_decoder_top_tb.sv
